// ===== design/ata_pio_pkg.sv =====
// Shared types, codes and constants for the ATA PIO sector sequencer.
`timescale 1ns / 1ps

package ata_pio_pkg;

   localparam int WORDS_PER_SECTOR_DEF = 256;
   localparam logic [23:0] POLL_LIMIT_RST = 24'd1000000;

   localparam logic [7:0] ST_BSY = 8'h80;
   localparam logic [7:0] ST_DRQ = 8'h08;
   localparam logic [7:0] ST_ERR = 8'h01;

   localparam logic [7:0] DRIVE_LBA = 8'hE0;
   localparam logic [7:0] CMD_READ = 8'h20;
   localparam logic [7:0] CMD_WRITE = 8'h30;

   localparam logic [1:0] MODE_START_RD = 2'd0;
   localparam logic [1:0] MODE_START_WR = 2'd1;
   localparam logic [1:0] MODE_STATUS = 2'd2;
   localparam logic [1:0] MODE_DATA = 2'd3;

   typedef enum logic [2:0] {
      K_REPORT = 3'd0,
      K_BWR = 3'd1,
      K_BRD = 3'd2,
      K_WRD = 3'd3,
      K_WWR = 3'd4,
      K_REQ = 3'd5
   } access_kind_type;

   typedef enum logic [2:0] {
      OFF_DATA = 3'd0,
      OFF_NONE = 3'd1,
      OFF_COUNT = 3'd2,
      OFF_LBA0 = 3'd3,
      OFF_LBA1 = 3'd4,
      OFF_LBA2 = 3'd5,
      OFF_DRIVE = 3'd6,
      OFF_STATUS = 3'd7
   } reg_offset_type;

   typedef enum logic [2:0] {
      OC_RUNNING = 3'd0,
      OC_DONE = 3'd1,
      OC_BSY_TIMEOUT = 3'd2,
      OC_DRQ_TIMEOUT = 3'd3,
      OC_DEV_ERROR = 3'd4,
      OC_DONE_TIMEOUT = 3'd5
   } outcome_type;

   // Shape of the result list that one request causes
   typedef enum logic [3:0] {
      B_START = 4'd0,   // drive select, five status reads
      B_CMD = 4'd1,     // count, lba bytes, command, status read
      B_POLL = 4'd2,    // one status read
      B_REPORT = 4'd3,  // one report carrying an outcome
      B_REQ = 4'd4,     // request write data
      B_WRD = 4'd5,     // one word read
      B_RDATA = 4'd6,   // read data report, then next access
      B_WDATA = 4'd7    // word write, then next access
   } burst_kind_type;

   typedef struct packed {
      burst_kind_type burst;
      logic [27:0] addr;
      logic flag;            // writing for B_CMD, last word for data bursts
      logic [15:0] word;
      logic [8:0] bi;
      logic [8:0] bi_next;
      outcome_type outcome;
   } burst_desc_type;

   function automatic logic [2:0] burst_len(input burst_kind_type b);
      logic [2:0] n;
      case (b)
         B_START, B_CMD: n = 3'd6;
         B_RDATA, B_WDATA: n = 3'd2;
         default: n = 3'd1;
      endcase
      return n;
   endfunction

endpackage

// ===== design/ata_pio_sector_sequencer.sv =====
// Top level of the ATA PIO LBA28 single-sector transfer sequencer.
`timescale 1ns / 1ps

// channel | handshake              | payload
// --------+------------------------+-------------------------------------------
// req     | req_valid / req_stall  | mode, lba, status_byte, data_word
// rsp     | rsp_valid / rsp_stall  | access_kind, reg_offset, write_value,
//         |                        | sector_data, byte_index, outcome, last
// csr     | csr_valid / csr_ready  | poll_limit (always ready)
//
// A request is decoded in the cycle it is accepted; its list of one, two or six
// results leaves the result register one per cycle while rsp_stall is low.
// The next request is taken in the cycle the last result of the previous one goes.
// Requests the current phase does not expect are taken and give no result.
// Synchronous reset returns to idle with poll_limit at 1000000; no clearing pass.

module ata_pio_sector_sequencer
   import ata_pio_pkg::*;
#(
   parameter int WORDS_PER_SECTOR = WORDS_PER_SECTOR_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_mode,
   input  logic [27:0] req_lba,
   input  logic [7:0] req_status_byte,
   input  logic [15:0] req_data_word,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [2:0] rsp_access_kind,
   output logic [2:0] rsp_reg_offset,
   output logic [15:0] rsp_write_value,
   output logic [15:0] rsp_sector_data,
   output logic [8:0] rsp_byte_index,
   output logic [2:0] rsp_outcome,
   output logic rsp_last,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [23:0] csr_poll_limit
);

   logic [23:0] poll_limit_ff, poll_limit_in;
   logic free;
   logic accept;
   logic load;
   burst_desc_type desc;

   assign csr_ready = 1'b1;
   assign poll_limit_in = (csr_valid && csr_ready) ? csr_poll_limit : poll_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff <= POLL_LIMIT_RST;
      end else begin
         poll_limit_ff <= poll_limit_in;
      end
   end

   assign req_stall = !free;
   assign accept = req_valid && free;

   ata_pio_ctrl #(
      .WORDS_PER_SECTOR(WORDS_PER_SECTOR)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .mode(req_mode),
      .lba(req_lba),
      .status_byte(req_status_byte),
      .data_word(req_data_word),
      .poll_limit(poll_limit_ff),
      .load(load),
      .desc(desc)
   );

   ata_pio_emit u_emit (
      .clock(clock),
      .reset(reset),
      .load(load),
      .desc(desc),
      .rsp_stall(rsp_stall),
      .free(free),
      .rsp_valid(rsp_valid),
      .rsp_access_kind(rsp_access_kind),
      .rsp_reg_offset(rsp_reg_offset),
      .rsp_write_value(rsp_write_value),
      .rsp_sector_data(rsp_sector_data),
      .rsp_byte_index(rsp_byte_index),
      .rsp_outcome(rsp_outcome),
      .rsp_last(rsp_last)
   );

endmodule

// ===== design/ata_pio_ctrl.sv =====
// Phase tracking, poll counting and result-list selection per request.
`timescale 1ns / 1ps

module ata_pio_ctrl
   import ata_pio_pkg::*;
#(
   parameter int WORDS_PER_SECTOR = WORDS_PER_SECTOR_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic [1:0] mode,
   input  logic [27:0] lba,
   input  logic [7:0] status_byte,
   input  logic [15:0] data_word,
   input  logic [23:0] poll_limit,
   output logic load,
   output burst_desc_type desc
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_WAIT_BSY,
      PH_WAIT_DRQ,
      PH_READ_DATA,
      PH_WRITE_DATA,
      PH_WAIT_DONE,
      PH_FINAL,
      PH_HALTED
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [23:0] polls_ff, polls_in;
   logic [8:0] wc_ff, wc_in;
   logic writing_ff, writing_in;
   logic [27:0] addr_ff, addr_in;

   logic [8:0] wc_plus;
   logic wc_last;
   logic bsy, drq, err;

   assign wc_plus = wc_ff + 9'd1;
   assign wc_last = (wc_plus >= 9'(WORDS_PER_SECTOR));
   assign bsy = (status_byte & ST_BSY) != 8'd0;
   assign drq = (status_byte & ST_DRQ) != 8'd0;
   assign err = (status_byte & ST_ERR) != 8'd0;

   always_comb begin
      outcome_type tmo;
      tmo = OC_BSY_TIMEOUT;
      phase_in = phase_ff;
      polls_in = polls_ff;
      wc_in = wc_ff;
      writing_in = writing_ff;
      addr_in = addr_ff;
      load = 1'b0;
      desc = '0;
      desc.burst = B_POLL;
      desc.addr = addr_ff;
      desc.flag = writing_ff;
      desc.word = data_word;
      desc.bi = {wc_ff[7:0], 1'b0};
      desc.bi_next = {wc_plus[7:0], 1'b0};
      desc.outcome = OC_RUNNING;
      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (mode == MODE_START_RD || mode == MODE_START_WR) begin
                  writing_in = mode[0];
                  addr_in = lba;
                  polls_in = poll_limit;
                  phase_in = PH_WAIT_BSY;
                  load = 1'b1;
                  desc.burst = B_START;
                  desc.addr = lba;
               end
            end
            PH_WAIT_BSY, PH_WAIT_DRQ, PH_WAIT_DONE, PH_FINAL: begin
               if (mode == MODE_STATUS) begin
                  load = 1'b1;
                  // every case not settled below is a failed poll
                  if (phase_ff == PH_WAIT_BSY) tmo = OC_BSY_TIMEOUT;
                  else if (phase_ff == PH_WAIT_DRQ) tmo = OC_DRQ_TIMEOUT;
                  else tmo = OC_DONE_TIMEOUT;
                  if (phase_ff != PH_WAIT_BSY && err) begin
                     phase_in = PH_HALTED;
                     desc.burst = B_REPORT;
                     desc.outcome = OC_DEV_ERROR;
                  end else if (phase_ff == PH_FINAL) begin
                     phase_in = PH_IDLE;
                     desc.burst = B_REPORT;
                     desc.outcome = OC_DONE;
                  end else if (phase_ff == PH_WAIT_BSY && !bsy) begin
                     polls_in = poll_limit;
                     phase_in = PH_WAIT_DRQ;
                     desc.burst = B_CMD;
                  end else if (phase_ff == PH_WAIT_DRQ && !bsy && drq) begin
                     wc_in = 9'd0;
                     desc.bi = 9'd0;
                     if (writing_ff) begin
                        phase_in = PH_WRITE_DATA;
                        desc.burst = B_REQ;
                     end else begin
                        phase_in = PH_READ_DATA;
                        desc.burst = B_WRD;
                     end
                  end else if (phase_ff == PH_WAIT_DONE && !bsy) begin
                     phase_in = PH_FINAL;
                     desc.burst = B_POLL;
                  end else if (polls_ff <= 24'd1) begin
                     polls_in = 24'd0;
                     phase_in = PH_HALTED;
                     desc.burst = B_REPORT;
                     desc.outcome = tmo;
                  end else begin
                     polls_in = polls_ff - 24'd1;
                     desc.burst = B_POLL;
                  end
               end
            end
            PH_READ_DATA, PH_WRITE_DATA: begin
               if (mode == MODE_DATA) begin
                  load = 1'b1;
                  wc_in = wc_plus;
                  desc.flag = wc_last;
                  if (phase_ff == PH_READ_DATA) begin
                     desc.burst = B_RDATA;
                     if (wc_last) phase_in = PH_FINAL;
                  end else begin
                     desc.burst = B_WDATA;
                     if (wc_last) begin
                        polls_in = poll_limit;
                        phase_in = PH_WAIT_DONE;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         polls_ff <= 24'd0;
         wc_ff <= 9'd0;
         writing_ff <= 1'b0;
         addr_ff <= 28'd0;
      end else begin
         phase_ff <= phase_in;
         polls_ff <= polls_in;
         wc_ff <= wc_in;
         writing_ff <= writing_in;
         addr_ff <= addr_in;
      end
   end

endmodule

// ===== design/ata_pio_emit.sv =====
// Result register: holds one result list and hands it out one access per cycle while rsp_stall is low.
`timescale 1ns / 1ps

module ata_pio_emit
   import ata_pio_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  burst_desc_type desc,
   input  logic rsp_stall,
   output logic free,
   output logic rsp_valid,
   output logic [2:0] rsp_access_kind,
   output logic [2:0] rsp_reg_offset,
   output logic [15:0] rsp_write_value,
   output logic [15:0] rsp_sector_data,
   output logic [8:0] rsp_byte_index,
   output logic [2:0] rsp_outcome,
   output logic rsp_last
);

   burst_desc_type desc_ff, desc_in;
   logic busy_ff, busy_in;
   logic [2:0] idx_ff, idx_in;

   logic is_last;
   logic take;
   access_kind_type kind;
   reg_offset_type off;

   assign is_last = (idx_ff == burst_len(desc_ff.burst) - 3'd1);
   assign take = busy_ff && !rsp_stall;
   assign free = !busy_ff || (take && is_last);

   always_comb begin
      desc_in = desc_ff;
      busy_in = busy_ff;
      idx_in = idx_ff;
      if (take) begin
         idx_in = idx_ff + 3'd1;
         if (is_last) busy_in = 1'b0;
      end
      if (load) begin
         desc_in = desc;
         busy_in = 1'b1;
         idx_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
      end
      desc_ff <= desc_in;
   end

   always_comb begin
      kind = K_BRD;
      off = OFF_STATUS;
      rsp_write_value = 16'd0;
      rsp_sector_data = 16'd0;
      rsp_byte_index = 9'd0;
      rsp_outcome = OC_RUNNING;
      unique case (desc_ff.burst)
         B_START: begin
            if (idx_ff == 3'd0) begin
               kind = K_BWR;
               off = OFF_DRIVE;
               rsp_write_value = {8'd0, DRIVE_LBA | {4'd0, desc_ff.addr[27:24]}};
            end
         end
         B_CMD: begin
            if (idx_ff != 3'd5) kind = K_BWR;
            case (idx_ff)
               3'd0: begin
                  off = OFF_COUNT;
                  rsp_write_value = 16'd1;
               end
               3'd1: begin
                  off = OFF_LBA0;
                  rsp_write_value = {8'd0, desc_ff.addr[7:0]};
               end
               3'd2: begin
                  off = OFF_LBA1;
                  rsp_write_value = {8'd0, desc_ff.addr[15:8]};
               end
               3'd3: begin
                  off = OFF_LBA2;
                  rsp_write_value = {8'd0, desc_ff.addr[23:16]};
               end
               3'd4: rsp_write_value = {8'd0, desc_ff.flag ? CMD_WRITE : CMD_READ};
               default: ;
            endcase
         end
         B_POLL: ;
         B_REPORT: begin
            kind = K_REPORT;
            off = OFF_DATA;
            rsp_outcome = desc_ff.outcome;
         end
         B_REQ: begin
            kind = K_REQ;
            off = OFF_DATA;
            rsp_byte_index = desc_ff.bi;
         end
         B_WRD: begin
            kind = K_WRD;
            off = OFF_DATA;
         end
         B_RDATA: begin
            if (idx_ff == 3'd0) begin
               kind = K_REPORT;
               off = OFF_DATA;
               rsp_sector_data = desc_ff.word;
               rsp_byte_index = desc_ff.bi;
            end else if (!desc_ff.flag) begin
               kind = K_WRD;
               off = OFF_DATA;
            end
         end
         B_WDATA: begin
            if (idx_ff == 3'd0) begin
               kind = K_WWR;
               off = OFF_DATA;
               rsp_write_value = desc_ff.word;
               rsp_byte_index = desc_ff.bi;
            end else if (!desc_ff.flag) begin
               kind = K_REQ;
               off = OFF_DATA;
               rsp_byte_index = desc_ff.bi_next;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = busy_ff;
   assign rsp_access_kind = kind;
   assign rsp_reg_offset = off;
   assign rsp_last = is_last;

endmodule
